>>> hdl/lzsd_pkg.sv
// Shared constants and types for the LZSS stream decoder.
// No dependencies.
`default_nettype none

package lzsd_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
   localparam int LENGTH_BITS  = 4;
   localparam int BYTE_BITS    = 8;
   localparam int FLAG_BITS    = 3;
   localparam logic [FLAG_BITS-1:0] FLAG_LAST = 3'd7;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_TOKEN,
      PH_PAIR
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

>>> hdl/lzsd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lzsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/lzss_stream_decoder.sv
// LZSS stream decoder top level: token parser, copy sequencer, output register.
// Depends on lzsd_pkg and lzsd_ram (4096-byte history window).
// A literal is shown in the cycle after its item is accepted. A copy hands out
// its bytes in turn, each byte passing through a read, a write/load and a
// hand-off state; the output register stalls while rsp_ready is low, and no new
// item is accepted until the last byte of the current item has been taken.
// Synchronous reset clears all parser state; the history is not cleared.
`default_nettype none

module lzss_stream_decoder
   import lzsd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [BYTE_BITS-1:0] req_in_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [BYTE_BITS-1:0] rsp_out_byte,
   output logic                      rsp_last_of_run,
   output logic                      rsp_end_of_stream
);

   state_type                 state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   logic [ADDR_BITS-1:0]      wp_ff, wp_in;
   logic [ADDR_BITS-1:0]      src_ff, src_in;
   logic [BYTE_BITS-1:0]      flags_ff, flags_in;
   logic [FLAG_BITS-1:0]      used_ff, used_in;
   logic [BYTE_BITS-1:0]      high_ff, high_in;
   logic [LENGTH_BITS-1:0]    cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   logic [BYTE_BITS-1:0]      byte_ff, byte_in;
   logic                      last_ff, last_in;
   logic                      end_ff, end_in;

   logic                      ram_wr_en;
   logic [ADDR_BITS-1:0]      ram_wr_addr;
   logic [BYTE_BITS-1:0]      ram_wr_data;
   logic                      ram_rd_en;
   logic [BYTE_BITS-1:0]      ram_rd_data;

   logic                      accept;
   logic [ADDR_BITS-1:0]      offset;
   logic [LENGTH_BITS-1:0]    len_low;

   lzsd_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (src_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ready         = (state_ff == ST_IDLE);
   assign accept            = req_valid && req_ready;
   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_out_byte      = byte_ff;
   assign rsp_last_of_run   = last_ff;
   assign rsp_end_of_stream = end_ff;

   assign offset  = {high_ff, req_in_byte[BYTE_BITS-1:LENGTH_BITS]};
   assign len_low = req_in_byte[LENGTH_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FLAG;
         wp_ff    <= '0;
         flags_ff <= '0;
         used_ff  <= '0;
         high_ff  <= '0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         wp_ff    <= wp_in;
         flags_ff <= flags_in;
         used_ff  <= used_in;
         high_ff  <= high_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      end_ff  <= end_in;
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      wp_in       = wp_ff;
      src_in      = src_ff;
      flags_in    = flags_ff;
      used_in     = used_ff;
      high_in     = high_ff;
      cnt_in      = cnt_ff;
      done_in     = done_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      end_in      = end_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wp_ff;
      ram_wr_data = req_in_byte;
      ram_rd_en   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !done_ff) begin
               unique case (phase_ff)
                  PH_TOKEN: begin
                     if (!flags_ff[0]) begin
                        // literal: store, show, consume flag
                        ram_wr_en = 1'b1;
                        wp_in     = wp_ff + 1'b1;
                        byte_in   = req_in_byte;
                        last_in   = 1'b1;
                        end_in    = 1'b0;
                        state_in  = ST_OUT;
                        flags_in  = flags_ff >> 1;
                        if (used_ff == FLAG_LAST) begin
                           used_in  = '0;
                           phase_in = PH_FLAG;
                        end else begin
                           used_in  = used_ff + 1'b1;
                        end
                     end else begin
                        high_in  = req_in_byte;
                        phase_in = PH_PAIR;
                     end
                  end
                  PH_PAIR: begin
                     if (len_low == '0) begin
                        done_in  = 1'b1;
                        byte_in  = '0;
                        last_in  = 1'b1;
                        end_in   = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        src_in   = wp_ff - offset - 1'b1;
                        cnt_in   = len_low;
                        state_in = ST_READ;
                        flags_in = flags_ff >> 1;
                        if (used_ff == FLAG_LAST) begin
                           used_in  = '0;
                           phase_in = PH_FLAG;
                        end else begin
                           used_in  = used_ff + 1'b1;
                           phase_in = PH_TOKEN;
                        end
                     end
                  end
                  default: begin
                     flags_in = req_in_byte;
                     used_in  = '0;
                     phase_in = PH_TOKEN;
                  end
               endcase
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            // copied byte goes back into the window; cnt holds bytes left after it
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
            wp_in       = wp_ff + 1'b1;
            src_in      = src_ff + 1'b1;
            byte_in     = ram_rd_data;
            last_in     = (cnt_ff == '0);
            end_in      = 1'b0;
            cnt_in      = cnt_ff - 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = (last_ff) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> test/lzss_stream_decoder_test.sv
// Self-checking testbench for lzss_stream_decoder: builds a well-formed compressed stream,
// decodes it alongside the block and compares every output byte with the prediction.
// Depends on lzsd_pkg and the lzss_stream_decoder RTL.
`timescale 1ns / 100ps

module lzss_stream_decoder_test;
   import lzsd_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int TAIL_CYCLES = 60;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data;
      logic                 last;
      logic                 eos;
   } dec_byte_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [BYTE_BITS-1:0] req_in_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [BYTE_BITS-1:0] rsp_out_byte;
   logic                 rsp_last_of_run;
   logic                 rsp_end_of_stream;

   // decoder image kept by the testbench
   logic [BYTE_BITS-1:0] window_img [WINDOW_DEPTH];
   logic [ADDR_BITS-1:0] wr_ptr;
   logic [BYTE_BITS-1:0] flag_reg;
   logic [FLAG_BITS-1:0] flags_taken;
   phase_type            dec_phase;
   logic [BYTE_BITS-1:0] pair_hi;
   logic                 dec_done;
   int                   written;
   dec_byte_type         decoded_q[$];

   // stream generator controls
   logic [ADDR_BITS-1:0]   pair_off;
   logic [LENGTH_BITS-1:0] pair_code;
   bit                     idle_en;
   bit                     all_copies;
   bit                     long_copies;
   bit                     far_reach;
   bit                     want_end;
   int                     hold_left;
   int                     stall_left;

   int cycle_cnt;
   int n_items;
   int n_results;
   int n_literals;
   int n_copies;
   int n_far;
   int n_errors;

   lzss_stream_decoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d bytes outstanding", $time, cycle_cnt,
                  decoded_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // output side: random stall bursts plus an optional long hold
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_output
      dec_byte_type want;
      dec_byte_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_byte, rsp_last_of_run, rsp_end_of_stream};
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected item data=%02h last=%b eos=%b", $time, got.data,
                     got.last, got.eos);
            n_errors++;
         end else begin
            want = decoded_q.pop_front();
            n_results++;
            if (got !== want) begin
               $display("%0t: mismatch expected data=%02h last=%b eos=%b,", $time,
                        want.data, want.last, want.eos,
                        " actual data=%02h last=%b eos=%b", got.data, got.last, got.eos);
               n_errors++;
            end
         end
      end
   end

   function automatic void store_hist(input logic [BYTE_BITS-1:0] v);
      window_img[wr_ptr] = v;
      wr_ptr++;
      if (written < WINDOW_DEPTH) written++;
   endfunction

   function automatic void advance_flag();
      flag_reg = flag_reg >> 1;
      if (flags_taken == FLAG_LAST) begin
         flags_taken = '0;
         dec_phase   = PH_FLAG;
      end else begin
         flags_taken++;
         dec_phase = PH_TOKEN;
      end
   endfunction

   // decode one stream byte and queue the bytes it produces
   function automatic void decode_byte(input logic [BYTE_BITS-1:0] b);
      logic [ADDR_BITS-1:0] reach;
      logic [ADDR_BITS-1:0] src;
      logic [BYTE_BITS-1:0] v;
      int                   len;
      if (dec_done) return;
      case (dec_phase)
         PH_TOKEN: begin
            if (!flag_reg[0]) begin
               store_hist(b);
               decoded_q.push_back('{b, 1'b1, 1'b0});
               n_literals++;
               advance_flag();
            end else begin
               pair_hi   = b;
               dec_phase = PH_PAIR;
            end
         end
         PH_PAIR: begin
            reach = {pair_hi, b[BYTE_BITS-1:LENGTH_BITS]};
            len   = int'(b[LENGTH_BITS-1:0]) + 1;
            if (len == 1) begin
               dec_done = 1'b1;
               decoded_q.push_back('{8'h00, 1'b1, 1'b1});
            end else begin
               src = wr_ptr - reach - 1'b1;
               for (int i = 0; i < len; i++) begin
                  v = window_img[src];
                  store_hist(v);
                  src++;
                  decoded_q.push_back('{v, (i == len - 1), 1'b0});
               end
               n_copies++;
               if (reach == WINDOW_DEPTH - 1) n_far++;
               advance_flag();
            end
         end
         default: begin
            flag_reg    = b;
            flags_taken = '0;
            dec_phase   = PH_TOKEN;
         end
      endcase
   endfunction

   // offer one item; valid stays up afterwards until the next item or sender_off
   task automatic push_byte(input logic [BYTE_BITS-1:0] b);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_items++;
      decode_byte(b);
   endtask

   task automatic sender_off();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   task automatic push_copy(input int off, input int len);
      logic [ADDR_BITS-1:0]   o;
      logic [LENGTH_BITS-1:0] c;
      o = ADDR_BITS'(off);
      c = LENGTH_BITS'(len - 1);
      push_byte(o[ADDR_BITS-1:LENGTH_BITS]);
      push_byte({o[LENGTH_BITS-1:0], c});
   endtask

   // choose the next byte of a well-formed stream from the current parser phase
   task automatic send_next();
      logic [BYTE_BITS-1:0] b;
      int                   lim;
      int                   r;
      b = BYTE_BITS'($urandom_range(0, 255));
      if (!dec_done) begin
         case (dec_phase)
            PH_TOKEN: begin
               if (flag_reg[0]) begin
                  if (want_end) begin
                     pair_off  = ADDR_BITS'($urandom_range(0, WINDOW_DEPTH - 1));
                     pair_code = '0;
                  end else begin
                     // never reach back past the first byte written
                     lim = (written >= WINDOW_DEPTH) ? WINDOW_DEPTH - 1 : written - 1;
                     r   = $urandom_range(0, 7);
                     if (far_reach && written >= WINDOW_DEPTH && r < 4)
                        pair_off = ADDR_BITS'(WINDOW_DEPTH - 1);
                     else if (r == 0)
                        pair_off = ADDR_BITS'(lim);
                     else if (r < 3)
                        pair_off = ADDR_BITS'($urandom_range(0, (lim < 20) ? lim : 20));
                     else
                        pair_off = ADDR_BITS'($urandom_range(0, lim));
                     r = $urandom_range(0, 7);
                     if (long_copies || r < 2)
                        pair_code = 4'hf;
                     else if (r == 2)
                        pair_code = 4'h1;
                     else
                        pair_code = LENGTH_BITS'($urandom_range(1, 15));
                  end
                  b = pair_off[ADDR_BITS-1:LENGTH_BITS];
               end
            end
            PH_PAIR: b = {pair_off[LENGTH_BITS-1:0], pair_code};
            default: begin
               r = $urandom_range(0, 7);
               if (all_copies || r == 0)
                  b = 8'hff;
               else if (r == 1)
                  b = 8'h00;
               if (want_end) b[0] = 1'b1;
            end
         endcase
      end
      push_byte(b);
   endtask

   task automatic test_directed();
      // literals at the byte extremes, overlapping copy, shortest and longest copies
      push_byte(8'he0);
      push_byte(8'h00);
      push_byte(8'hff);
      push_byte(8'ha5);
      push_byte(8'h5a);
      push_byte(8'h01);
      push_copy(0, 16);
      push_copy(4, 2);
      push_copy(15, 5);
      push_byte(8'h05);
      push_copy(20, 3);
      push_byte(8'h80);
      push_copy(1, 15);
      push_byte(8'h7f);
   endtask

   task automatic test_output_hold();
      // output blocked for a long stretch while input keeps coming
      hold_left = 300;
      repeat (40) send_next();
   endtask

   task automatic test_drain_pause();
      sender_off();
      wait_drained();
      repeat (10) send_next();
   endtask

   task automatic test_random();
      for (int chunk = 0; chunk < 4; chunk++) begin
         idle_en = (chunk % 4 != 3);
         repeat (30) send_next();
      end
   endtask

   task automatic test_far_reach();
      // fill the whole window with long copies, then reach the full distance back
      idle_en     = 1'b0;
      all_copies  = 1'b1;
      long_copies = 1'b1;
      while (written < WINDOW_DEPTH) send_next();
      all_copies  = 1'b0;
      long_copies = 1'b0;
      far_reach   = 1'b1;
      repeat (30) send_next();
      far_reach = 1'b0;
   endtask

   task automatic test_end_of_stream();
      want_end = 1'b1;
      while (!dec_done) send_next();
      // bytes after the end marker are dropped
      repeat (6) send_next();
      sender_off();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = '0;
      rsp_ready   = 1'b0;
      wr_ptr      = '0;
      flag_reg    = '0;
      flags_taken = '0;
      dec_phase   = PH_FLAG;
      pair_hi     = '0;
      dec_done    = 1'b0;
      written     = 0;
      pair_off    = '0;
      pair_code   = '0;
      idle_en     = 1'b1;
      all_copies  = 1'b0;
      long_copies = 1'b0;
      far_reach   = 1'b0;
      want_end    = 1'b0;
      hold_left   = 0;
      stall_left  = 0;
      cycle_cnt   = 0;
      n_items     = 0;
      n_results   = 0;
      n_literals  = 0;
      n_copies    = 0;
      n_far       = 0;
      n_errors    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_output_hold();
      test_drain_pause();
      test_random();
      test_far_reach();
      test_end_of_stream();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items: %0d literals, %0d copies (%0d at full window distance).",
               n_items, n_literals, n_copies, n_far);
      $display("Checked %0d output items, end marker reached: %0d, errors: %0d.",
               n_results, dec_done, n_errors);
      if (n_errors == 0 && decoded_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/lzsd_pkg.sv
hdl/lzsd_ram.sv
hdl/lzss_stream_decoder.sv
test/lzss_stream_decoder_test.sv
